FILE: design/hpr_pkg.sv
// ============================================================================
// hpr_pkg
// Shared constants, types and helper functions of the hazard pointer
// reclaimer: list geometry, operation codes and the request structs.
// ============================================================================
`timescale 1ns / 1ps

package hpr_pkg;

    // Geometry of the thread table and of each thread's retired list.
    localparam int THREAD_SLOTS = 8;
    localparam int ADDR_WIDTH   = 32;
    localparam int LIST_LEN     = THREAD_SLOTS + 1;
    localparam int THREAD_W     = 3;
    localparam int COL_W        = $clog2(LIST_LEN);
    localparam int CNT_W        = $clog2(LIST_LEN + 1);
    localparam int ENTRY_DEPTH  = THREAD_SLOTS * LIST_LEN;
    localparam int ENTRY_AW     = $clog2(ENTRY_DEPTH);

    // Port widths fixed by the interface.
    localparam int MODE_W     = 2;
    localparam int OUT_ADDR_W = 32;
    localparam int PEND_W     = 4;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int NT_W       = 4;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_PROTECT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RETIRE  = 2'd2;

    // Result word kinds.
    localparam logic KIND_DONE  = 1'b0;
    localparam logic KIND_FREED = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_THREADS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETIRE_THRESHOLD = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [NT_W-1:0]  ACTIVE_THREADS_RST = 4'd8;
    localparam logic [CFG_W-1:0] THRESHOLD_RST      = 4'd4;

    typedef logic [LIST_LEN-1:0] row_t;

    // Write request to the hazard slot table.
    typedef struct packed {
        logic                  en;
        logic [THREAD_W-1:0]   idx;
        logic [ADDR_WIDTH-1:0] data;
    } slot_wr_t;

    // Access request to the retired list store; all ports address one thread.
    typedef struct packed {
        logic                  rd_en;
        logic [COL_W-1:0]      rd_col;
        logic                  wr_en;
        logic [COL_W-1:0]      wr_col;
        logic [ADDR_WIDTH-1:0] wr_data;
        logic                  clr_en;
        logic [COL_W-1:0]      clr_col;
    } list_req_t;

    // Flat memory address of one list entry.
    function automatic logic [ENTRY_AW-1:0] entry_addr(input logic [THREAD_W-1:0] thread,
                                                       input logic [COL_W-1:0] col);
        return ENTRY_AW'(thread) * ENTRY_AW'(LIST_LEN) + ENTRY_AW'(col);
    endfunction

    // Index of the lowest set bit of a row, zero when none is set.
    function automatic logic [COL_W-1:0] first_one(input row_t v);
        logic [COL_W-1:0] idx;
        idx = '0;
        for (int i = LIST_LEN - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = COL_W'(i);
            end
        end
        return idx;
    endfunction

    // Number of occupied entries in a row.
    function automatic logic [CNT_W-1:0] row_count(input row_t v);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < LIST_LEN; i++) begin
            c = c + CNT_W'(v[i]);
        end
        return c;
    endfunction

endpackage

FILE: design/hpr_slots.sv
// ============================================================================
// hpr_slots
// Hazard slot table, one published address per thread, with a parallel
// match of one candidate address against the slots of the active threads.
// ============================================================================
`timescale 1ns / 1ps

module hpr_slots (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hpr_pkg::slot_wr_t             slot_wr,
    input  logic [hpr_pkg::NT_W-1:0]       active_threads,
    input  logic [hpr_pkg::ADDR_WIDTH-1:0] match_addr,
    output logic                          hit
);
    import hpr_pkg::*;

    logic [ADDR_WIDTH-1:0] slot_reg [THREAD_SLOTS];
    logic [NT_W-1:0]       scan_n;

    // Slots start out null and are written by protect and clear.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < THREAD_SLOTS; j++) begin
                slot_reg[j] <= '0;
            end
        end else if (slot_wr.en) begin
            slot_reg[slot_wr.idx] <= slot_wr.data;
        end
    end

    // Thread count saturates at the table size.
    assign scan_n = (active_threads > NT_W'(THREAD_SLOTS)) ? NT_W'(THREAD_SLOTS)
                                                           : active_threads;

    // Compare the candidate against every active slot at once.
    always_comb begin
        hit = 1'b0;
        for (int j = 0; j < THREAD_SLOTS; j++) begin
            if ((NT_W'(j) < scan_n) && (slot_reg[j] == match_addr)) begin
                hit = 1'b1;
            end
        end
    end

endmodule

FILE: design/hpr_list_mem.sv
// ============================================================================
// hpr_list_mem
// Retired list store: a synchronous memory of all threads' list entries
// with a registered read, plus an occupancy bit per entry.
// ============================================================================
`timescale 1ns / 1ps

module hpr_list_mem (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [hpr_pkg::THREAD_W-1:0]   thread,
    input  hpr_pkg::list_req_t            req,
    output logic [hpr_pkg::ADDR_WIDTH-1:0] rd_data,
    output hpr_pkg::row_t                 row
);
    import hpr_pkg::*;

    logic [ADDR_WIDTH-1:0] mem [ENTRY_DEPTH];
    logic [ADDR_WIDTH-1:0] rd_data_reg;
    row_t                  valid_reg [THREAD_SLOTS];

    // Entry storage; read data is held until the next read.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[entry_addr(thread, req.wr_col)] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[entry_addr(thread, req.rd_col)];
        end
    end

    // Occupancy bits: an entry whose bit is low is empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < THREAD_SLOTS; t++) begin
                valid_reg[t] <= '0;
            end
        end else begin
            if (req.wr_en) begin
                valid_reg[thread][req.wr_col] <= 1'b1;
            end
            if (req.clr_en) begin
                valid_reg[thread][req.clr_col] <= 1'b0;
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign row     = valid_reg[thread];

endmodule

FILE: design/hazard_pointer_reclaimer.sv
// ============================================================================
// hazard_pointer_reclaimer
// Each operation is accepted, executed and completed with a completion word; a
// retire adds a threshold test and, above the limit, a reclamation pass: nine
// entry reads checked against the active threads' slots at once, then a read
// back and a result word per freed entry. One operation at a time: the next
// word is taken only once the completion word is loaded; output stalls delay it.
// Synchronous active-low reset empties all lists and slots, 8 threads, limit 4.
// ============================================================================
`timescale 1ns / 1ps

module hazard_pointer_reclaimer (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Operation words
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [hpr_pkg::MODE_W-1:0]       s_mode,
    input  logic [hpr_pkg::THREAD_W-1:0]     s_thread,
    input  logic [hpr_pkg::OUT_ADDR_W-1:0]   s_address,
    // Result words
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_kind,
    output logic [hpr_pkg::OUT_ADDR_W-1:0]   m_address_out,
    output logic [hpr_pkg::PEND_W-1:0]       m_pending,
    output logic                            m_dropped,
    output logic                            m_last,
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hpr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hpr_pkg::CFG_W-1:0]        cfg_data
);
    import hpr_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_EXEC    = 7'b0000010,
        ST_TEST    = 7'b0000100,
        ST_SCAN    = 7'b0001000,
        ST_EMIT_RD = 7'b0010000,
        ST_EMIT_WR = 7'b0100000,
        ST_DONE    = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [THREAD_W-1:0]   thread_reg, thread_next;
    logic [ADDR_WIDTH-1:0] addr_reg, addr_next;
    logic                  drop_reg, drop_next;
    row_t                  mask_reg, mask_next;
    logic [CNT_W-1:0]      scan_rd_reg, scan_rd_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [COL_W-1:0]      cmp_col_reg, cmp_col_next;
    logic [NT_W-1:0]       active_threads_reg;
    logic [CFG_W-1:0]      retire_thr_reg;

    logic                  m_valid_reg, m_valid_next;
    logic                  m_kind_reg, m_kind_next;
    logic [OUT_ADDR_W-1:0] m_addr_reg, m_addr_next;
    logic [PEND_W-1:0]     m_pend_reg, m_pend_next;
    logic                  m_drop_reg, m_drop_next;
    logic                  m_last_reg, m_last_next;

    slot_wr_t              slot_wr;
    list_req_t             list_req;
    logic [ADDR_WIDTH-1:0] list_rdata;
    row_t                  list_row;
    logic [CNT_W-1:0]      row_cnt;
    logic                  slot_hit;
    logic                  out_free;
    logic [COL_W-1:0]      emit_col;

    hpr_slots u_slots (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .slot_wr        (slot_wr),
        .active_threads (active_threads_reg),
        .match_addr     (list_rdata),
        .hit            (slot_hit)
    );

    hpr_list_mem u_list (
        .aclk    (aclk),
        .aresetn (aresetn),
        .thread  (thread_reg),
        .req     (list_req),
        .rd_data (list_rdata),
        .row     (list_row)
    );

    assign row_cnt  = row_count(list_row);
    assign out_free = !m_valid_reg || m_ready;
    assign emit_col = first_one(mask_reg);
    assign s_ready  = (state_reg == ST_IDLE);

    // Configuration registers are always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_threads_reg <= ACTIVE_THREADS_RST;
            retire_thr_reg     <= THRESHOLD_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ACTIVE_THREADS:   active_threads_reg <= cfg_data;
                CFG_RETIRE_THRESHOLD: retire_thr_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: execute the operation, then for a retire above the limit scan and emit, and complete.
    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        thread_next  = thread_reg;
        addr_next    = addr_reg;
        drop_next    = drop_reg;
        mask_next    = mask_reg;
        scan_rd_next = scan_rd_reg;
        cmp_vld_next = 1'b0;
        cmp_col_next = cmp_col_reg;

        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_addr_next  = m_addr_reg;
        m_pend_next  = m_pend_reg;
        m_drop_next  = m_drop_reg;
        m_last_next  = m_last_reg;

        slot_wr  = '0;
        list_req = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next   = s_mode;
                    thread_next = s_thread;
                    addr_next   = ADDR_WIDTH'(s_address);
                    drop_next   = 1'b0;
                    state_next  = ST_EXEC;
                end
            end

            ST_EXEC: begin
                case (mode_reg)
                    MODE_PROTECT: begin
                        slot_wr.en   = 1'b1;
                        slot_wr.idx  = thread_reg;
                        slot_wr.data = addr_reg;
                        state_next   = ST_DONE;
                    end
                    MODE_CLEAR: begin
                        slot_wr.en   = 1'b1;
                        slot_wr.idx  = thread_reg;
                        slot_wr.data = '0;
                        state_next   = ST_DONE;
                    end
                    MODE_RETIRE: begin
                        // A null address stores nothing; a full list drops it.
                        if (addr_reg != '0) begin
                            if (~list_row != '0) begin
                                list_req.wr_en   = 1'b1;
                                list_req.wr_col  = first_one(~list_row);
                                list_req.wr_data = addr_reg;
                            end else begin
                                drop_next = 1'b1;
                            end
                        end
                        state_next = ST_TEST;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_TEST: begin
                if (CFG_W'(row_cnt) > retire_thr_reg) begin
                    scan_rd_next = '0;
                    mask_next    = '0;
                    state_next   = ST_SCAN;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_SCAN: begin
                // Read stage: one entry per cycle.
                if (scan_rd_reg < CNT_W'(LIST_LEN)) begin
                    list_req.rd_en  = 1'b1;
                    list_req.rd_col = scan_rd_reg[COL_W-1:0];
                    scan_rd_next    = scan_rd_reg + CNT_W'(1);
                    cmp_vld_next    = 1'b1;
                    cmp_col_next    = scan_rd_reg[COL_W-1:0];
                end
                // Compare stage: free an occupied entry that no active thread's slot protects.
                if (cmp_vld_reg) begin
                    if (list_row[cmp_col_reg] && !slot_hit) begin
                        list_req.clr_en        = 1'b1;
                        list_req.clr_col       = cmp_col_reg;
                        mask_next[cmp_col_reg] = 1'b1;
                    end
                    if (cmp_col_reg == COL_W'(LIST_LEN - 1)) begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            ST_EMIT_RD: begin
                // The freed entry's data is still in memory; fetch it again.
                if (mask_reg != '0) begin
                    list_req.rd_en      = 1'b1;
                    list_req.rd_col     = emit_col;
                    mask_next[emit_col] = 1'b0;
                    state_next          = ST_EMIT_WR;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_EMIT_WR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_FREED;
                    m_addr_next  = OUT_ADDR_W'(list_rdata);
                    m_pend_next  = PEND_W'(row_cnt);
                    m_drop_next  = 1'b0;
                    m_last_next  = 1'b0;
                    state_next   = ST_EMIT_RD;
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_DONE;
                    m_addr_next  = (mode_reg == MODE_PROTECT) ? OUT_ADDR_W'(addr_reg) : '0;
                    m_pend_next  = PEND_W'(row_cnt);
                    m_drop_next  = drop_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mask_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mask_reg    <= mask_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Operation and result payload.
    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        thread_reg  <= thread_next;
        addr_reg    <= addr_next;
        drop_reg    <= drop_next;
        scan_rd_reg <= scan_rd_next;
        cmp_col_reg <= cmp_col_next;
        m_kind_reg  <= m_kind_next;
        m_addr_reg  <= m_addr_next;
        m_pend_reg  <= m_pend_next;
        m_drop_reg  <= m_drop_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_address_out = m_addr_reg;
    assign m_pending     = m_pend_reg;
    assign m_dropped     = m_drop_reg;
    assign m_last        = m_last_reg;

    // A reclamation pass never raises the thread's pending count.
    a_scan_no_growth: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |=> (row_cnt <= $past(row_cnt)))
        else $error("pending count grew during a reclamation pass");

    // Entries waiting to be emitted have already been emptied.
    a_mask_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT_RD) |-> ((mask_reg & list_row) == '0))
        else $error("entry marked freed is still occupied");

    // No freed entry is left behind when a new word is taken.
    a_idle_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (mask_reg == '0))
        else $error("freed entries left unreported");

    // A freed word never carries a null address.
    a_freed_nonnull: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_FREED)) |-> (m_address_out != '0))
        else $error("null address reported as freed");

    // Only the completion word can report a drop.
    a_drop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_dropped) |-> (m_last && (m_kind == KIND_DONE)))
        else $error("drop flag on a word other than the completion word");

endmodule
